### hw/rtl/xxtea_block_cipher_macros.svh
// Assertion macros shared by the XXTEA checker.
`ifndef XXTEA_BLOCK_CIPHER_MACROS_SVH
`define XXTEA_BLOCK_CIPHER_MACROS_SVH

// The enclosing scope must provide clk and rst_n.
`define XXTEA_ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error(msg);

`define XXTEA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/xxtea_pkg.sv
// Shared types, constants, microcode and mix function of the XXTEA engine.
package xxtea_pkg;

    localparam int WORD_W = 32;
    localparam int CNT_W = 6;
    localparam int CFG_IDX_W = 3;
    localparam int MAX_WORDS_DEFAULT = 32;

    localparam logic [WORD_W-1:0] DELTA = 32'h9e3779b9;
    // Six times the delta, modulo two to the 32nd.
    localparam logic [WORD_W-1:0] DEC_SUM_BASE = 32'hb54cda56;
    localparam logic [CNT_W-1:0] BASE_ROUNDS = 6'd6;
    localparam logic [CNT_W-1:0] ROUND_NUMER = 6'd52;
    localparam logic [CNT_W-1:0] MIN_WORDS = 6'd2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_KEY0    = 3'd0,
        CFG_KEY1    = 3'd1,
        CFG_KEY2    = 3'd2,
        CFG_KEY3    = 3'd3,
        CFG_WCOUNT  = 3'd4,
        CFG_DECRYPT = 3'd5
    } cfg_idx_t;

    typedef enum logic [2:0] {
        OP_LOAD      = 3'd0,
        OP_DIV       = 3'd1,
        OP_PRE0      = 3'd2,
        OP_PRE1      = 3'd3,
        OP_PRE2      = 3'd4,
        OP_MIX       = 3'd5,
        OP_OUT_PRIME = 3'd6,
        OP_OUT_SEND  = 3'd7
    } dp_op_t;

    typedef enum logic [2:0] {
        COND_NONE = 3'd0,
        COND_LOAD = 3'd1,
        COND_DIV  = 3'd2,
        COND_MIX  = 3'd3,
        COND_OUT  = 3'd4
    } cond_t;

    typedef logic [2:0] step_t;

    localparam step_t STEP_LOAD      = 3'd0;
    localparam step_t STEP_DIV       = 3'd1;
    localparam step_t STEP_PRE0      = 3'd2;
    localparam step_t STEP_PRE1      = 3'd3;
    localparam step_t STEP_PRE2      = 3'd4;
    localparam step_t STEP_MIX       = 3'd5;
    localparam step_t STEP_OUT_PRIME = 3'd6;
    localparam step_t STEP_OUT_SEND  = 3'd7;

    typedef struct packed {
        logic   in_ready;
        logic   out_valid;
        dp_op_t op;
        cond_t  cond;
        step_t  target;
    } ctrl_t;

    typedef struct packed {
        logic load_wait;
        logic div_more;
        logic mix_more;
        logic out_wait;
    } status_t;

    // When the selected condition holds the sequencer jumps to target,
    // otherwise it falls through to the next step (the last step wraps).
    function automatic ctrl_t ucode_rom(step_t s);
        ctrl_t w;
        w = '{in_ready: 1'b0, out_valid: 1'b0, op: OP_LOAD, cond: COND_NONE,
              target: STEP_LOAD};
        case (s)
            STEP_LOAD:
            begin
                w.in_ready = 1'b1;
                w.op = OP_LOAD;
                w.cond = COND_LOAD;
                w.target = STEP_LOAD;
            end
            STEP_DIV:
            begin
                w.op = OP_DIV;
                w.cond = COND_DIV;
                w.target = STEP_DIV;
            end
            STEP_PRE0:      w.op = OP_PRE0;
            STEP_PRE1:      w.op = OP_PRE1;
            STEP_PRE2:      w.op = OP_PRE2;
            STEP_MIX:
            begin
                w.op = OP_MIX;
                w.cond = COND_MIX;
                w.target = STEP_MIX;
            end
            STEP_OUT_PRIME: w.op = OP_OUT_PRIME;
            STEP_OUT_SEND:
            begin
                w.out_valid = 1'b1;
                w.op = OP_OUT_SEND;
                w.cond = COND_OUT;
                w.target = STEP_OUT_SEND;
            end
            default:
            begin
                w.in_ready = 1'b1;
            end
        endcase
        return w;
    endfunction

    function automatic logic [WORD_W-1:0] xxtea_mix(
        logic [WORD_W-1:0] y,
        logic [WORD_W-1:0] z,
        logic [WORD_W-1:0] sum,
        logic [WORD_W-1:0] k
    );
        logic [WORD_W-1:0] a;
        logic [WORD_W-1:0] b;
        a = ((z >> 5) ^ (y << 2)) + ((y >> 3) ^ (z << 4));
        b = (sum ^ y) + (k ^ z);
        return a ^ b;
    endfunction

endpackage

### hw/rtl/xxtea_word_if.sv
// Channel interface carrying block words into the engine.
interface xxtea_word_if import xxtea_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [WORD_W-1:0] in_word;

    modport source (output valid, output in_word, input ready);
    modport sink (input valid, input in_word, output ready);
endinterface

### hw/rtl/xxtea_result_if.sv
// Channel interface carrying processed words out of the engine.
interface xxtea_result_if import xxtea_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [WORD_W-1:0] out_word;
    logic              last_out;

    modport source (output valid, output out_word, output last_out, input ready);
    modport sink (input valid, input out_word, input last_out, output ready);
endinterface

### hw/rtl/xxtea_cfg_if.sv
// Register write channel interface of the engine.
interface xxtea_cfg_if import xxtea_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [WORD_W-1:0]    data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

### hw/rtl/xxtea_ram.sv
// Generic single-write, single-read RAM with registered read data.
module xxtea_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

### hw/rtl/xxtea_seq.sv
// Microcode sequencer: step counter, control store and conditional jumps.
module xxtea_seq import xxtea_pkg::*; (
    input  logic    clk,
    input  logic    rst_n,
    input  status_t status,
    output ctrl_t   ctrl
);

    step_t step_reg;
    step_t step_next;
    logic  jump;

    assign ctrl = ucode_rom(step_reg);

    always_comb
    begin
        case (ctrl.cond)
            COND_NONE: jump = 1'b0;
            COND_LOAD: jump = status.load_wait;
            COND_DIV:  jump = status.div_more;
            COND_MIX:  jump = status.mix_more;
            COND_OUT:  jump = status.out_wait;
            default:   jump = 1'b0;
        endcase
        step_next = jump ? ctrl.target : step_reg + 3'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= STEP_LOAD;
        end
        else
        begin
            step_reg <= step_next;
        end
    end

endmodule

### hw/rtl/xxtea_dp.sv
// Datapath: configuration registers, block store, round counters and mix unit.
module xxtea_dp import xxtea_pkg::*; #(
    parameter int MAX_WORDS = MAX_WORDS_DEFAULT
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  ctrl_t                ctrl,
    input  logic                 in_fire,
    input  logic [WORD_W-1:0]    in_word,
    input  logic                 out_fire,
    input  logic                 cfg_fire,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [WORD_W-1:0]    cfg_data,
    output status_t              status,
    output logic [WORD_W-1:0]    out_word,
    output logic                 last_out
);

    localparam int AW = $clog2(MAX_WORDS);
    localparam int CW1 = CNT_W + 1;
    localparam logic [CNT_W:0] MAX_EXT = CW1'(MAX_WORDS);

    logic [WORD_W-1:0] key0_reg, key1_reg, key2_reg, key3_reg;
    logic [CNT_W-1:0]  word_count_reg;
    logic              decrypt_reg;
    logic [CNT_W-1:0]  load_count_reg;

    logic [CNT_W-1:0]  rem_reg;
    logic [CNT_W-1:0]  rounds_reg;
    logic [WORD_W-1:0] sum_reg;
    logic [WORD_W-1:0] carry_reg;
    logic [WORD_W-1:0] v_reg;
    logic [AW-1:0]     p_reg;
    logic              byp_reg;
    logic [WORD_W-1:0] byp_data_reg;

    logic [CNT_W:0]    wc_ext;
    logic [CNT_W:0]    n_ext;
    logic [CNT_W-1:0]  n_w;
    logic [AW-1:0]     last_idx;
    logic [CNT_W-1:0]  lc_inc;
    logic              lc_in_range;
    logic              load_done;

    logic [AW-1:0]     p_inc, p_dec, p_step, s_inc, s_dec, nb_next;
    logic              round_end;
    logic              out_last;
    logic [1:0]        key_sel;
    logic [WORD_W-1:0] key_word;
    logic [WORD_W-1:0] nb_word, y_word, z_word, mix_word, new_word;

    logic              wr_en, rd_en;
    logic [AW-1:0]     wr_addr, rd_addr;
    logic [WORD_W-1:0] wr_data, rd_data;

    always_comb
    begin
        wc_ext = {1'b0, word_count_reg};
        if (wc_ext < {1'b0, MIN_WORDS})
        begin
            n_ext = {1'b0, MIN_WORDS};
        end
        else if (wc_ext > MAX_EXT)
        begin
            n_ext = MAX_EXT;
        end
        else
        begin
            n_ext = wc_ext;
        end
        n_w = n_ext[CNT_W-1:0];
        last_idx = AW'(n_w - 6'd1);
    end

    assign lc_inc = load_count_reg + 6'd1;
    assign lc_in_range = {1'b0, load_count_reg} < MAX_EXT;
    assign load_done = in_fire && (lc_inc >= n_w);

    always_comb
    begin
        p_inc = (p_reg == last_idx) ? '0 : p_reg + 1'b1;
        p_dec = (p_reg == '0) ? last_idx : p_reg - 1'b1;
        p_step = decrypt_reg ? p_dec : p_inc;
        s_inc = (p_step == last_idx) ? '0 : p_step + 1'b1;
        s_dec = (p_step == '0) ? last_idx : p_step - 1'b1;
        nb_next = decrypt_reg ? s_dec : s_inc;
        round_end = decrypt_reg ? (p_reg == '0) : (p_reg == last_idx);
        out_last = (p_reg == last_idx);
    end

    always_comb
    begin
        key_sel = 2'(p_reg) ^ sum_reg[3:2];
        case (key_sel)
            2'd0:    key_word = key0_reg;
            2'd1:    key_word = key1_reg;
            2'd2:    key_word = key2_reg;
            default: key_word = key3_reg;
        endcase
        nb_word = byp_reg ? byp_data_reg : rd_data;
        y_word = decrypt_reg ? carry_reg : nb_word;
        z_word = decrypt_reg ? nb_word : carry_reg;
        mix_word = xxtea_mix(y_word, z_word, sum_reg, key_word);
        new_word = decrypt_reg ? v_reg - mix_word : v_reg + mix_word;
    end

    always_comb
    begin
        wr_en = 1'b0;
        wr_addr = p_reg;
        wr_data = new_word;
        rd_en = 1'b0;
        rd_addr = p_reg;
        case (ctrl.op)
            OP_LOAD:
            begin
                wr_en = in_fire && lc_in_range;
                wr_addr = load_count_reg[AW-1:0];
                wr_data = in_word;
            end
            OP_PRE0:
            begin
                rd_en = 1'b1;
                rd_addr = decrypt_reg ? '0 : last_idx;
            end
            OP_PRE1:
            begin
                rd_en = 1'b1;
                rd_addr = decrypt_reg ? last_idx : '0;
            end
            OP_PRE2:
            begin
                rd_en = 1'b1;
                rd_addr = p_step;
            end
            OP_MIX:
            begin
                wr_en = 1'b1;
                rd_en = 1'b1;
                rd_addr = nb_next;
            end
            OP_OUT_PRIME:
            begin
                rd_en = 1'b1;
                rd_addr = '0;
            end
            OP_OUT_SEND:
            begin
                rd_en = out_fire && !out_last;
                rd_addr = p_inc;
            end
            default:
            begin
                rd_en = 1'b0;
            end
        endcase
    end

    xxtea_ram #(
        .WIDTH (WORD_W),
        .DEPTH (MAX_WORDS)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key0_reg <= '0;
            key1_reg <= '0;
            key2_reg <= '0;
            key3_reg <= '0;
            word_count_reg <= MIN_WORDS;
            decrypt_reg <= 1'b0;
            load_count_reg <= '0;
        end
        else
        begin
            if (cfg_fire)
            begin
                case (cfg_index)
                    CFG_KEY0:    key0_reg <= cfg_data;
                    CFG_KEY1:    key1_reg <= cfg_data;
                    CFG_KEY2:    key2_reg <= cfg_data;
                    CFG_KEY3:    key3_reg <= cfg_data;
                    CFG_WCOUNT:  word_count_reg <= cfg_data[CNT_W-1:0];
                    CFG_DECRYPT: decrypt_reg <= cfg_data[0];
                    default:     decrypt_reg <= decrypt_reg;
                endcase
            end
            if (ctrl.op == OP_LOAD && in_fire)
            begin
                load_count_reg <= load_done ? '0 : lc_inc;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        byp_reg <= rd_en && wr_en && (rd_addr == wr_addr);
        byp_data_reg <= wr_data;
        case (ctrl.op)
            OP_LOAD:
            begin
                if (in_fire)
                begin
                    rem_reg <= ROUND_NUMER;
                    rounds_reg <= BASE_ROUNDS;
                    sum_reg <= DEC_SUM_BASE;
                end
            end
            OP_DIV:
            begin
                if (rem_reg >= n_w)
                begin
                    rem_reg <= rem_reg - n_w;
                    rounds_reg <= rounds_reg + 6'd1;
                    sum_reg <= sum_reg + DELTA;
                end
            end
            OP_PRE0:
            begin
                if (!decrypt_reg)
                begin
                    sum_reg <= DELTA;
                end
                p_reg <= decrypt_reg ? last_idx : '0;
            end
            OP_PRE1:
            begin
                carry_reg <= rd_data;
            end
            OP_PRE2:
            begin
                v_reg <= rd_data;
            end
            OP_MIX:
            begin
                carry_reg <= new_word;
                v_reg <= nb_word;
                p_reg <= p_step;
                if (round_end)
                begin
                    rounds_reg <= rounds_reg - 6'd1;
                    sum_reg <= decrypt_reg ? sum_reg - DELTA : sum_reg + DELTA;
                end
            end
            OP_OUT_PRIME:
            begin
                p_reg <= '0;
            end
            OP_OUT_SEND:
            begin
                if (out_fire && !out_last)
                begin
                    p_reg <= p_inc;
                end
            end
            default:
            begin
                p_reg <= p_reg;
            end
        endcase
    end

    assign status.load_wait = !load_done;
    assign status.div_more = (rem_reg >= n_w);
    assign status.mix_more = !(round_end && (rounds_reg == 6'd1));
    assign status.out_wait = !(out_fire && out_last);

    assign out_word = rd_data;
    assign last_out = out_last;

endmodule

### hw/rtl/xxtea_block_cipher.sv
// Top level of the XXTEA block engine: sequencer, datapath and channels.
//
// Usage: write the key words, the word count and the mode on the cfg channel
// while the engine is idle; cfg is always ready. Then send the words of one
// block, in index order, one beat each on the words channel. The beat that
// brings the n-th word closes the block, where n is the word count held
// between 2 and MAX_WORDS. The engine then runs the cipher in place and
// returns the n processed words on the results channel, last_out set on the
// final beat. The words channel is not ready from the closing beat until the
// final result beat is taken.
// After the closing beat the engine derives the round count in the DIV step,
// primes the operands in the PRE0, PRE1 and PRE2 steps, then runs 6 + 52/n
// rounds of word updates, one per cycle through the single mix unit and the
// one-write, one-read block store; that update loop sets the throughput. The
// OUT_PRIME step then reads the first result, and one result leaves per cycle
// while the receiver is ready; a stalled beat is held unchanged.
// Reset clears the configuration to its defaults and the load count to zero.
module xxtea_block_cipher import xxtea_pkg::*; #(
    parameter int MAX_WORDS = MAX_WORDS_DEFAULT
) (
    input logic            clk,
    input logic            rst_n,
    xxtea_word_if.sink     words,
    xxtea_result_if.source results,
    xxtea_cfg_if.sink      cfg
);

    ctrl_t   ctrl;
    status_t status;
    logic    in_fire;
    logic    out_fire;
    logic    cfg_fire;

    assign words.ready = ctrl.in_ready;
    assign results.valid = ctrl.out_valid;
    assign cfg.ready = 1'b1;

    assign in_fire = words.valid && words.ready;
    assign out_fire = results.valid && results.ready;
    assign cfg_fire = cfg.valid && cfg.ready;

    xxtea_seq u_seq (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .ctrl   (ctrl)
    );

    xxtea_dp #(
        .MAX_WORDS (MAX_WORDS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (ctrl),
        .in_fire   (in_fire),
        .in_word   (words.in_word),
        .out_fire  (out_fire),
        .cfg_fire  (cfg_fire),
        .cfg_index (cfg.index),
        .cfg_data  (cfg.data),
        .status    (status),
        .out_word  (results.out_word),
        .last_out  (results.last_out)
    );

endmodule

### hw/rtl/xxtea_checker.sv
// Port-level checker for the XXTEA engine and its bind to the top level.
`include "xxtea_block_cipher_macros.svh"

module xxtea_checker (
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_ready,
    input logic out_valid,
    input logic out_ready,
    input logic last_out
);

    // The engine never takes words while results are pending.
    `XXTEA_ASSERT_ALWAYS(a_no_overlap, !(in_ready && out_valid), "input ready during output")

    // A word beat is never followed at once by a result beat.
    `XXTEA_ASSERT_NEXT(a_in_then_quiet, in_valid && in_ready, !out_valid, "result right after input")

    // Results of one block come as an unbroken run.
    `XXTEA_ASSERT_NEXT(a_burst_continues, out_valid && out_ready && !last_out, out_valid, "block output cut short")

    // After the final beat the engine is ready for the next block.
    `XXTEA_ASSERT_NEXT(a_ready_after_last, out_valid && out_ready && last_out, in_ready && !out_valid, "not ready after last beat")

endmodule

bind xxtea_block_cipher xxtea_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (words.valid),
    .in_ready  (words.ready),
    .out_valid (results.valid),
    .out_ready (results.ready),
    .last_out  (results.last_out)
);

### dv/xxtea_block_cipher_checker.sv
// Checker for the XXTEA engine: tracks register beats, predicts each block and compares results.
module xxtea_block_cipher_checker
    import xxtea_pkg::*;
#(
    parameter int MAX_WORDS = MAX_WORDS_DEFAULT
) (
    input  logic    clk,
    input  logic    rst_n,
    xxtea_word_if   words,
    xxtea_result_if results,
    xxtea_cfg_if    cfg,
    output int      errors,
    output int      pending
);

    localparam logic [WORD_W-1:0] GOLDEN = 32'h9e3779b9;

    typedef struct {
        logic [WORD_W-1:0] word;
        logic              last;
    } cipher_beat_t;

    cipher_beat_t      cipher_queue[$];
    cipher_beat_t      head;
    logic [WORD_W-1:0] key_regs[4];
    logic [CNT_W-1:0]  count_reg;
    logic              decrypt_reg;
    logic [WORD_W-1:0] block_words[MAX_WORDS];
    logic [CNT_W-1:0]  loaded;
    int                mismatches = 0;
    int                outstanding = 0;

    assign errors = mismatches;
    assign pending = outstanding;

    function automatic int block_size();
        int n;
        n = int'(count_reg);
        if (n < 2)
            n = 2;
        if (n > MAX_WORDS)
            n = MAX_WORDS;
        return n;
    endfunction

    function automatic logic [WORD_W-1:0] mix_word(
        input logic [WORD_W-1:0] y,
        input logic [WORD_W-1:0] z,
        input logic [WORD_W-1:0] sum,
        input int                p,
        input logic [1:0]        e
    );
        logic [WORD_W-1:0] shifts;
        logic [WORD_W-1:0] keyed;
        shifts = ((z >> 5) ^ (y << 2)) + ((y >> 3) ^ (z << 4));
        keyed = (sum ^ y) + (key_regs[2'(p) ^ e] ^ z);
        return shifts ^ keyed;
    endfunction

    function automatic void encipher_block(input int n);
        int                rounds;
        int                p;
        logic [WORD_W-1:0] sum;
        logic [WORD_W-1:0] y;
        logic [WORD_W-1:0] z;
        logic [1:0]        e;
        rounds = 6 + 52 / n;
        sum = '0;
        z = block_words[n-1];
        repeat (rounds)
        begin
            sum = sum + GOLDEN;
            e = sum[3:2];
            for (p = 0; p < n; p++)
            begin
                y = block_words[(p + 1 < n) ? p + 1 : 0];
                block_words[p] = block_words[p] + mix_word(y, z, sum, p, e);
                z = block_words[p];
            end
        end
    endfunction

    function automatic void decipher_block(input int n);
        int                rounds;
        int                p;
        logic [WORD_W-1:0] sum;
        logic [WORD_W-1:0] y;
        logic [WORD_W-1:0] z;
        logic [1:0]        e;
        rounds = 6 + 52 / n;
        sum = GOLDEN * rounds;
        y = block_words[0];
        repeat (rounds)
        begin
            e = sum[3:2];
            for (p = n - 1; p >= 0; p--)
            begin
                z = block_words[(p > 0) ? p - 1 : n - 1];
                block_words[p] = block_words[p] - mix_word(y, z, sum, p, e);
                y = block_words[p];
            end
            sum = sum - GOLDEN;
        end
    endfunction

    function automatic void absorb_word(input logic [WORD_W-1:0] w);
        int n;
        int i;
        n = block_size();
        if (loaded < MAX_WORDS)
            block_words[loaded] = w;
        loaded = loaded + 1'b1;
        if (loaded >= n)
        begin
            if (decrypt_reg)
                decipher_block(n);
            else
                encipher_block(n);
            for (i = 0; i < n; i++)
                cipher_queue.push_back('{word: block_words[i], last: (i == n - 1)});
            loaded = '0;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            foreach (key_regs[i])
                key_regs[i] = '0;
            count_reg = MIN_WORDS;
            decrypt_reg = 1'b0;
            loaded = '0;
            cipher_queue.delete();
            outstanding = 0;
        end
        else
        begin
            if (results.valid && results.ready)
            begin
                if (cipher_queue.size() == 0)
                begin
                    $error("out_word: no result expected, actual %h", results.out_word);
                    mismatches++;
                end
                else
                begin
                    head = cipher_queue.pop_front();
                    if (results.out_word !== head.word)
                    begin
                        $error("out_word: expected %h, actual %h", head.word, results.out_word);
                        mismatches++;
                    end
                    if (results.last_out !== head.last)
                    begin
                        $error("last_out: expected %b, actual %b", head.last, results.last_out);
                        mismatches++;
                    end
                end
            end
            if (cfg.valid && cfg.ready)
            begin
                case (cfg_idx_t'(cfg.index))
                    CFG_KEY0:    key_regs[0] = cfg.data;
                    CFG_KEY1:    key_regs[1] = cfg.data;
                    CFG_KEY2:    key_regs[2] = cfg.data;
                    CFG_KEY3:    key_regs[3] = cfg.data;
                    CFG_WCOUNT:  count_reg = cfg.data[CNT_W-1:0];
                    CFG_DECRYPT: decrypt_reg = cfg.data[0];
                    default:
                    begin
                    end
                endcase
            end
            if (words.valid && words.ready)
                absorb_word(words.in_word);
            outstanding = cipher_queue.size();
        end
    end

endmodule

### dv/xxtea_block_cipher_tb.sv
// Testbench top for the XXTEA engine: drives blocks and register writes and gives the verdict.
module xxtea_block_cipher_tb;
    import xxtea_pkg::*;

    localparam int BLOCK_MAX = 32;
    localparam int RANDOM_WORDS = 380;
    localparam int LONG_HOLD = 400;
    localparam int SETTLE_CYCLES = 8;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 3'd7;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    bit   no_gaps = 1'b0;
    bit   hold_request = 1'b0;
    int   mismatches;
    int   pending;
    int   random_words = 0;

    xxtea_word_if   words_if();
    xxtea_result_if results_if();
    xxtea_cfg_if    cfg_if();

    xxtea_block_cipher #(
        .MAX_WORDS(BLOCK_MAX)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .words(words_if),
        .results(results_if),
        .cfg(cfg_if)
    );

    xxtea_block_cipher_checker #(
        .MAX_WORDS(BLOCK_MAX)
    ) cipher_check (
        .clk(clk),
        .rst_n(rst_n),
        .words(words_if),
        .results(results_if),
        .cfg(cfg_if),
        .errors(mismatches),
        .pending(pending)
    );

    always #1 clk = ~clk;

    initial
    begin
        #1000000;
        $display("TB_ERROR");
        $finish;
    end

    function automatic logic [WORD_W-1:0] random_word();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            default: return $urandom;
        endcase
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [WORD_W-1:0] value);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data <= value;
        do @(posedge clk); while (!cfg_if.ready);
        @(negedge clk);
        cfg_if.valid <= 1'b0;
        @(negedge clk);
    endtask

    // The valid line stays high after a beat so that back-to-back words need no gap.
    task automatic send_word(input logic [WORD_W-1:0] w);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 10);
        if (gap > 0)
        begin
            words_if.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        words_if.valid <= 1'b1;
        words_if.in_word <= w;
        do @(posedge clk); while (!words_if.ready);
        @(negedge clk);
    endtask

    task automatic send_block(input int n);
        repeat (n)
        begin
            send_word(random_word());
            random_words++;
        end
    endtask

    task automatic settle();
        words_if.valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic setup_phase(input int phase, output int n);
        logic [CNT_W-1:0] count;
        int               pick;
        pick = $urandom_range(0, 99);
        if (phase == 0)
            count = 6'd32;
        else if (phase == 1)
            count = 6'd40;
        else if (phase == 2)
            count = 6'd4;
        else if (pick < 55)
            count = CNT_W'($urandom_range(2, 5));
        else if (pick < 75)
            count = CNT_W'($urandom_range(6, 16));
        else if (pick < 88)
            count = CNT_W'($urandom_range(17, 31));
        else if (pick < 93)
            count = 6'd32;
        else if (pick < 96)
            count = CNT_W'($urandom_range(0, 1));
        else
            count = CNT_W'($urandom_range(33, 63));
        write_reg(CFG_KEY0, random_word());
        write_reg(CFG_KEY1, random_word());
        write_reg(CFG_KEY2, random_word());
        write_reg(CFG_KEY3, random_word());
        write_reg(CFG_WCOUNT, {26'($urandom), count});
        write_reg(CFG_DECRYPT, {31'($urandom), 1'($urandom_range(0, 1))});
        if ($urandom_range(0, 7) == 0)
            write_reg(CFG_SPARE, $urandom);
        n = (count < 2) ? 2 : ((count > BLOCK_MAX) ? BLOCK_MAX : int'(count));
    endtask

    initial
    begin
        int stall;
        results_if.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                stall = LONG_HOLD;
                hold_request = 1'b0;
            end
            else
            begin
                stall = no_gaps ? 0 : $urandom_range(0, 10);
            end
            if (stall > 0)
            begin
                results_if.ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            results_if.ready <= 1'b1;
            do @(posedge clk); while (!results_if.valid);
        end
    end

    initial
    begin
        int phase;
        int n;
        int blocks;
        words_if.valid = 1'b0;
        words_if.in_word = '0;
        cfg_if.valid = 1'b0;
        cfg_if.index = CFG_KEY0;
        cfg_if.data = '0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Default zero key and two-word blocks, then the field extremes.
        send_word('0);
        send_word('0);
        send_word('1);
        send_word('1);
        settle();
        write_reg(CFG_KEY0, '1);
        write_reg(CFG_KEY1, '1);
        write_reg(CFG_KEY2, '1);
        write_reg(CFG_KEY3, '1);
        write_reg(CFG_DECRYPT, 32'd1);
        send_word('0);
        send_word('1);
        settle();
        // Word counts below two behave as two.
        write_reg(CFG_WCOUNT, 32'd0);
        send_word($urandom);
        send_word($urandom);
        settle();
        write_reg(CFG_WCOUNT, 32'd1);
        write_reg(CFG_DECRYPT, 32'd0);
        send_word($urandom);
        send_word($urandom);
        settle();
        write_reg(CFG_KEY0, $urandom);
        write_reg(CFG_WCOUNT, 32'd3);
        send_word($urandom);
        send_word($urandom);
        send_word($urandom);
        settle();
        // Count lowered below the words already loaded: the next word closes the block.
        write_reg(CFG_WCOUNT, 32'd5);
        send_word($urandom);
        send_word($urandom);
        send_word($urandom);
        settle();
        write_reg(CFG_WCOUNT, 32'd2);
        send_word($urandom);
        settle();
        // Key and mode changed with half a block loaded.
        send_word($urandom);
        settle();
        write_reg(CFG_KEY1, $urandom);
        write_reg(CFG_DECRYPT, 32'd1);
        send_word($urandom);

        phase = 0;
        while (random_words < RANDOM_WORDS)
        begin
            settle();
            no_gaps = ($urandom_range(0, 3) == 0);
            setup_phase(phase, n);
            blocks = $urandom_range(1, 4);
            if (phase == 2)
            begin
                no_gaps = 1'b0;
                hold_request = 1'b1;
                blocks = 3;
            end
            repeat (blocks)
            begin
                send_block(n);
                if ($urandom_range(0, 4) == 0)
                    settle();
            end
            if ($urandom_range(0, 9) == 0)
                send_block($urandom_range(1, n - 1));
            phase++;
        end

        settle();
        repeat (20) @(negedge clk);
        if (mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
